/* hw/rtl/tbu_pkg.sv */
// ----------------------------------------------------------------------------
// tbu_pkg: shared types and constants of the trailing block update unit
// Field widths, command and result records, extent record and sequencer states.
// ----------------------------------------------------------------------------
package tbu_pkg;

   localparam int IDX_W      = 3;
   localparam int VAL_W      = 32;
   localparam int EXT_W      = 4;
   localparam int ACC_W      = 64;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CMDQ_DEPTH = 4;
   localparam int RSPQ_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DEPTH = 2'd2;

   typedef enum logic [1:0] {
      ACT_LOAD_LEFT   = 2'd0,
      ACT_LOAD_WORK   = 2'd1,
      ACT_LOAD_TARGET = 2'd2,
      ACT_RUN         = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      action_type              action;
      logic [IDX_W-1:0]        first;
      logic [IDX_W-1:0]        second;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [EXT_W-1:0] rows;
      logic [EXT_W-1:0] cols;
      logic [EXT_W-1:0] depth;
   } ext_type;

endpackage

/* hw/rtl/tbu_ram.sv */
// ----------------------------------------------------------------------------
// tbu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbu_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tbu_front.sv */
// ----------------------------------------------------------------------------
// tbu_front: request intake and command queue
// Accept request transactions, drop loads that address outside the stores,
// and queue the rest for the execution side.
// ----------------------------------------------------------------------------
module tbu_front #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_COLS  = 8,
   parameter int MAX_INNER = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [1:0]                       req_action,
   input  logic [tbu_pkg::IDX_W-1:0]        req_first_index,
   input  logic [tbu_pkg::IDX_W-1:0]        req_second_index,
   input  logic signed [tbu_pkg::VAL_W-1:0] req_value,
   output logic                             cmd_valid,
   output tbu_pkg::cmd_type                 cmd,
   input  logic                             cmd_pop
);

   localparam int PTR_W = (tbu_pkg::CMDQ_DEPTH > 1) ? $clog2(tbu_pkg::CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(tbu_pkg::CMDQ_DEPTH + 1);

   tbu_pkg::cmd_type  mem_ff [tbu_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   tbu_pkg::cmd_type  cmd_in;
   logic              keep;
   logic              push;
   logic              pop;

   always_comb begin
      cmd_in.action = tbu_pkg::action_type'(req_action);
      cmd_in.first  = req_first_index;
      cmd_in.second = req_second_index;
      cmd_in.value  = req_value;
      unique case (cmd_in.action)
         tbu_pkg::ACT_LOAD_LEFT: begin
            keep = (32'(req_first_index) < MAX_INNER) && (32'(req_second_index) < MAX_ROWS);
         end
         tbu_pkg::ACT_LOAD_WORK: begin
            keep = (32'(req_first_index) < MAX_INNER) && (32'(req_second_index) < MAX_COLS);
         end
         tbu_pkg::ACT_LOAD_TARGET: begin
            keep = (32'(req_first_index) < MAX_ROWS) && (32'(req_second_index) < MAX_COLS);
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   assign req_full  = (count_ff == CNT_W'(tbu_pkg::CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = mem_ff[rd_ptr_ff];
   assign push      = req_push && !req_full && keep;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == tbu_pkg::CMDQ_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == tbu_pkg::CMDQ_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

/* hw/rtl/tbu_back.sv */
// ----------------------------------------------------------------------------
// tbu_back: command execution and result queue
// Write loads into the panel and target stores, sequence the multiply and
// accumulate for each target element of a run, and queue the results.
// ----------------------------------------------------------------------------
module tbu_back #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_COLS  = 8,
   parameter int MAX_INNER = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  tbu_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  tbu_pkg::ext_type ext,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tbu_pkg::rsp_type rsp
);

   localparam int LEFT_DEPTH = MAX_INNER * MAX_ROWS;
   localparam int WORK_DEPTH = MAX_INNER * MAX_COLS;
   localparam int TGT_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int LEFT_AW    = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
   localparam int WORK_AW    = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;
   localparam int TGT_AW     = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;
   localparam int PTR_W      = (tbu_pkg::RSPQ_DEPTH > 1) ? $clog2(tbu_pkg::RSPQ_DEPTH) : 1;
   localparam int CNT_W      = $clog2(tbu_pkg::RSPQ_DEPTH + 1);
   localparam int VAL_W      = tbu_pkg::VAL_W;
   localparam int ACC_W      = tbu_pkg::ACC_W;
   localparam int EXT_W      = tbu_pkg::EXT_W;
   localparam int IDX_W      = tbu_pkg::IDX_W;

   tbu_pkg::state_type       state_ff, state_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   tbu_pkg::ext_type         ext_ff, ext_in;
   tbu_pkg::ext_type         ext_cl;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     mul_vld_ff;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                     left_we, work_we, tgt_we;
   logic [LEFT_AW-1:0]       left_wa, left_ra;
   logic [WORK_AW-1:0]       work_wa, work_ra;
   logic [TGT_AW-1:0]        tgt_wa, tgt_ra;
   logic [VAL_W-1:0]         tgt_wd;
   logic                     run_re, tgt_re;
   logic [VAL_W-1:0]         left_rd, work_rd, tgt_rd;
   logic signed [VAL_W-1:0]  left_s, work_s, tgt_s;
   logic signed [ACC_W-1:0]  diff;
   logic signed [VAL_W-1:0]  sat;

   tbu_pkg::rsp_type         rq_mem_ff [tbu_pkg::RSPQ_DEPTH];
   logic [PTR_W-1:0]         rq_wr_ff, rq_wr_in;
   logic [PTR_W-1:0]         rq_rd_ff, rq_rd_in;
   logic [CNT_W-1:0]         rq_cnt_ff, rq_cnt_in;
   logic                     rq_full;
   logic                     rq_push;
   logic                     rq_pop;
   tbu_pkg::rsp_type         rq_data;
   logic                     last_col;
   logic                     last_row;

   tbu_ram #(.WIDTH(VAL_W), .DEPTH(LEFT_DEPTH), .ADDR_W(LEFT_AW)) u_left (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (left_wa),
      .wr_data (cmd.value),
      .rd_en   (run_re),
      .rd_addr (left_ra),
      .rd_data (left_rd)
   );

   tbu_ram #(.WIDTH(VAL_W), .DEPTH(WORK_DEPTH), .ADDR_W(WORK_AW)) u_work (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_wa),
      .wr_data (cmd.value),
      .rd_en   (run_re),
      .rd_addr (work_ra),
      .rd_data (work_rd)
   );

   tbu_ram #(.WIDTH(VAL_W), .DEPTH(TGT_DEPTH), .ADDR_W(TGT_AW)) u_target (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (tgt_wa),
      .wr_data (tgt_wd),
      .rd_en   (tgt_re),
      .rd_addr (tgt_ra),
      .rd_data (tgt_rd)
   );

   assign left_s = left_rd;
   assign work_s = work_rd;
   assign tgt_s  = tgt_rd;

   assign ext_cl.rows  = (32'(ext.rows) > MAX_ROWS) ? EXT_W'(MAX_ROWS) : ext.rows;
   assign ext_cl.cols  = (32'(ext.cols) > MAX_COLS) ? EXT_W'(MAX_COLS) : ext.cols;
   assign ext_cl.depth = (32'(ext.depth) > MAX_INNER) ? EXT_W'(MAX_INNER) : ext.depth;

   assign left_ra  = LEFT_AW'(k_ff * MAX_ROWS + i_ff);
   assign work_ra  = WORK_AW'(k_ff * MAX_COLS + j_ff);
   assign tgt_ra   = TGT_AW'(i_ff * MAX_COLS + j_ff);
   assign last_col = (EXT_W'(j_ff) + EXT_W'(1)) == ext_ff.cols;
   assign last_row = (EXT_W'(i_ff) + EXT_W'(1)) == ext_ff.rows;

   assign diff = ACC_W'(tgt_s) - acc_ff;
   always_comb begin
      if ((diff[ACC_W-1:VAL_W-1] == '0) || (diff[ACC_W-1:VAL_W-1] == '1)) begin
         sat = diff[VAL_W-1:0];
      end else if (diff[ACC_W-1]) begin
         sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   assign prod_in = left_s * work_s;
   assign rd_vld_in = (state_ff == tbu_pkg::ST_ISSUE);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      ext_in    = ext_ff;
      acc_in    = mul_vld_ff ? acc_ff + (prod_ff >>> tbu_pkg::FRAC_W) : acc_ff;
      cmd_pop   = 1'b0;
      left_we   = 1'b0;
      work_we   = 1'b0;
      tgt_we    = 1'b0;
      left_wa   = LEFT_AW'(cmd.first * MAX_ROWS + cmd.second);
      work_wa   = WORK_AW'(cmd.first * MAX_COLS + cmd.second);
      tgt_wa    = tgt_ra;
      tgt_wd    = cmd.value;
      run_re    = 1'b0;
      tgt_re    = 1'b0;
      rq_push   = 1'b0;
      rq_data.row   = i_ff;
      rq_data.col   = j_ff;
      rq_data.value = sat;
      rq_data.last  = last_row && last_col;
      unique case (state_ff)
         tbu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.action)
                  tbu_pkg::ACT_LOAD_LEFT: begin
                     left_we = 1'b1;
                  end
                  tbu_pkg::ACT_LOAD_WORK: begin
                     work_we = 1'b1;
                  end
                  tbu_pkg::ACT_LOAD_TARGET: begin
                     tgt_we = 1'b1;
                     tgt_wa = TGT_AW'(cmd.first * MAX_COLS + cmd.second);
                  end
                  default: begin
                     if ((ext_cl.rows != '0) && (ext_cl.cols != '0) && (ext_cl.depth != '0)) begin
                        state_in = tbu_pkg::ST_ISSUE;
                        ext_in   = ext_cl;
                        i_in     = '0;
                        j_in     = '0;
                        k_in     = '0;
                        acc_in   = '0;
                     end
                  end
               endcase
            end
         end
         tbu_pkg::ST_ISSUE: begin
            run_re = 1'b1;
            tgt_re = (k_ff == '0);
            if ((EXT_W'(k_ff) + EXT_W'(1)) == ext_ff.depth) begin
               k_in     = '0;
               state_in = tbu_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         default: begin
            if (!rd_vld_ff && !mul_vld_ff && !rq_full) begin
               tgt_we  = 1'b1;
               tgt_wd  = sat;
               rq_push = 1'b1;
               acc_in  = '0;
               if (last_col) begin
                  j_in = '0;
                  if (last_row) begin
                     state_in = tbu_pkg::ST_IDLE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = tbu_pkg::ST_ISSUE;
                  end
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = tbu_pkg::ST_ISSUE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tbu_pkg::ST_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      ext_ff  <= ext_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign rq_full   = (rq_cnt_ff == CNT_W'(tbu_pkg::RSPQ_DEPTH));
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp       = rq_mem_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      rq_wr_in  = rq_wr_ff;
      rq_rd_in  = rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (rq_push) begin
         rq_wr_in = (32'(rq_wr_ff) == tbu_pkg::RSPQ_DEPTH - 1) ? '0 : rq_wr_ff + PTR_W'(1);
      end
      if (rq_pop) begin
         rq_rd_in = (32'(rq_rd_ff) == tbu_pkg::RSPQ_DEPTH - 1) ? '0 : rq_rd_ff + PTR_W'(1);
      end
      if (rq_push && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + CNT_W'(1);
      end else if (rq_pop && !rq_push) begin
         rq_cnt_in = rq_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_mem_ff[rq_wr_ff] <= rq_data;
      end
   end

endmodule

/* hw/rtl/trailing_block_update_unit.sv */
// ----------------------------------------------------------------------------
// trailing_block_update_unit: Schur-complement trailing update
// Load transactions fill the left panel, workspace panel and target stores;
// a run transaction computes target[i][j] minus the sum over k of
// left[k][i] * work[k][j], each product shifted right by FRAC_W bits, for
// every element in the configured extent, writes it back saturated and
// returns it in row-major order with last on the final element. Load
// transactions are taken at one per cycle while no run is in progress and
// the command queue is not full. One 32x32 multiplier is shared over the
// inner products and each product waits on the registered store reads and
// the product register before it enters the accumulator. A run with a zero
// extent returns nothing. A four-entry command queue and a four-entry
// result queue sit on the two sides.
// ----------------------------------------------------------------------------
module trailing_block_update_unit #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_COLS  = 8,
   parameter int MAX_INNER = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [1:0]                           req_action,
   input  logic [tbu_pkg::IDX_W-1:0]            req_first_index,
   input  logic [tbu_pkg::IDX_W-1:0]            req_second_index,
   input  logic signed [tbu_pkg::VAL_W-1:0]     req_value,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [tbu_pkg::IDX_W-1:0]            rsp_row,
   output logic [tbu_pkg::IDX_W-1:0]            rsp_col,
   output logic signed [tbu_pkg::VAL_W-1:0]     rsp_value_res,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [tbu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tbu_pkg::EXT_W-1:0]            csr_wdata
);

   tbu_pkg::ext_type ext_ff, ext_in;
   tbu_pkg::cmd_type cmd;
   tbu_pkg::rsp_type rsp;
   logic             cmd_valid;
   logic             cmd_pop;

   always_comb begin
      ext_in = ext_ff;
      if (csr_we) begin
         unique case (csr_index)
            tbu_pkg::CSR_ROW_COUNT:   ext_in.rows  = csr_wdata;
            tbu_pkg::CSR_COL_COUNT:   ext_in.cols  = csr_wdata;
            tbu_pkg::CSR_INNER_DEPTH: ext_in.depth = csr_wdata;
            default:                  ext_in       = ext_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff <= '0;
      end else begin
         ext_ff <= ext_in;
      end
   end

   tbu_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_INNER(MAX_INNER)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_value        (req_value),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   tbu_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_INNER(MAX_INNER)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .ext       (ext_ff),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_row       = rsp.row;
   assign rsp_col       = rsp.col;
   assign rsp_value_res = rsp.value;
   assign rsp_last      = rsp.last;

endmodule

/* hw/rtl/tbu_checker.sv */
// ----------------------------------------------------------------------------
// tbu_checker: port-level checks of the trailing block update unit
// Track the configured extent and check queue state after reset, stall
// behavior and the position of each result against the extent.
// ----------------------------------------------------------------------------
module tbu_checker #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_full,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic [tbu_pkg::IDX_W-1:0]        rsp_row,
   input logic [tbu_pkg::IDX_W-1:0]        rsp_col,
   input logic signed [tbu_pkg::VAL_W-1:0] rsp_value_res,
   input logic                             rsp_last,
   input logic                             csr_we,
   input logic [tbu_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [tbu_pkg::EXT_W-1:0]        csr_wdata
);

   localparam int EXT_W = tbu_pkg::EXT_W;

   logic [EXT_W-1:0] rows_ff;
   logic [EXT_W-1:0] cols_ff;
   logic [EXT_W-1:0] rows_cl;
   logic [EXT_W-1:0] cols_cl;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
         cols_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == tbu_pkg::CSR_ROW_COUNT) begin
            rows_ff <= csr_wdata;
         end
         if (csr_index == tbu_pkg::CSR_COL_COUNT) begin
            cols_ff <= csr_wdata;
         end
      end
   end

   assign rows_cl = (32'(rows_ff) > MAX_ROWS) ? EXT_W'(MAX_ROWS) : rows_ff;
   assign cols_cl = (32'(cols_ff) > MAX_COLS) ? EXT_W'(MAX_COLS) : cols_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_row) && $stable(rsp_col)
         && $stable(rsp_value_res) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   a_rsp_in_extent: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (EXT_W'(rsp_row) < rows_cl) && (EXT_W'(rsp_col) < cols_cl))
      else $error("result outside configured extent");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last |-> (EXT_W'(rsp_row) + EXT_W'(1) == rows_cl)
         && (EXT_W'(rsp_col) + EXT_W'(1) == cols_cl))
      else $error("last flag away from final element");

endmodule

bind trailing_block_update_unit tbu_checker #(
   .MAX_ROWS (MAX_ROWS),
   .MAX_COLS (MAX_COLS)
) u_tbu_checker (.*);
